/* sv/gfd_pkg.sv */
// ============================================================================
// gfd_pkg
// Shared types and constants of the gaze fixation detector.
// ============================================================================
package gfd_pkg;

    localparam int POS_W    = 24;
    localparam int ID_W     = 16;
    localparam int DT_W     = 20;
    localparam int LIM_W    = 24;
    localparam int SUM_W    = 40;
    localparam int TIME_W   = 32;
    localparam int MEAN_W   = SUM_W + 1;
    localparam int SUB_W    = MEAN_W + 1;
    localparam int A_W      = 50;
    localparam int B_W      = 48;
    localparam int ACC_W    = 96;
    localparam int DIVD_W   = SUM_W;
    localparam int DVS_W    = 16;
    localparam int NB_W     = 6;
    localparam int SPEED_W  = 90;
    localparam int LSQ_W    = 88;
    localparam int C2_W     = 84;
    localparam int SPL2_W   = 48;
    localparam int PADDR_W  = 5;
    localparam int PDATA_W  = 32;

    localparam logic [B_W-1:0] US2_CONST = B_W'(64'd1000000000000);

    localparam logic [NB_W-1:0] NB_DIFF  = NB_W'(25);
    localparam logic [NB_W-1:0] NB_US2   = NB_W'(40);
    localparam logic [NB_W-1:0] NB_DT    = NB_W'(20);
    localparam logic [NB_W-1:0] NB_LIMDT = NB_W'(44);
    localparam logic [NB_W-1:0] NB_SPLIT = NB_W'(24);
    localparam logic [NB_W-1:0] NB_DIV   = NB_W'(40);
    localparam logic [NB_W-1:0] NB_C2    = NB_W'(41);

    localparam logic [2:0] REG_FIX_LIMIT = 3'd0;
    localparam logic [2:0] REG_SAC_LIMIT = 3'd1;
    localparam logic [2:0] REG_SPLIT     = 3'd2;
    localparam logic [2:0] REG_MIN_TIME  = 3'd3;
    localparam logic [2:0] REG_EMIT      = 3'd4;

    localparam logic [ID_W-1:0] NO_TARGET = '1;

    typedef enum logic {
        ALU_MUL,
        ALU_DIV
    } alu_op_t;

    typedef struct packed {
        logic            start;
        alu_op_t         op;
        logic            clear;
        logic [NB_W-1:0] nbits;
    } alu_cmd_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_D2X,
        ST_D2Y,
        ST_D2Z,
        ST_SPD,
        ST_FDT,
        ST_FSQ,
        ST_SDT,
        ST_SSQ,
        ST_SPLSQ,
        ST_DIVX,
        ST_DIVY,
        ST_DIVZ,
        ST_C2X,
        ST_C2Y,
        ST_C2Z,
        ST_CLOSE,
        ST_ADD
    } gfd_state_t;

endpackage

/* sv/gfd_if.sv */
// ============================================================================
// gfd_sample_if / gfd_group_if
// Valid/ready channels for gaze samples in and fixation groups out.
// ============================================================================
interface gfd_sample_if;
    logic                         valid;
    logic                         ready;
    logic                         sample_valid;
    logic signed [15:0]           target_id;
    logic signed [23:0]           pos_x;
    logic signed [23:0]           pos_y;
    logic signed [23:0]           pos_z;
    logic [19:0]                  elapsed_us;

    modport source (output valid, sample_valid, target_id, pos_x, pos_y, pos_z,
                    elapsed_us, input ready);
    modport sink (input valid, sample_valid, target_id, pos_x, pos_y, pos_z,
                  elapsed_us, output ready);
endinterface

interface gfd_group_if;
    logic                         valid;
    logic                         ready;
    logic signed [15:0]           group_target_id;
    logic signed [23:0]           centroid_x;
    logic signed [23:0]           centroid_y;
    logic signed [23:0]           centroid_z;
    logic [31:0]                  fixation_us;

    modport source (output valid, group_target_id, centroid_x, centroid_y,
                    centroid_z, fixation_us, input ready);
    modport sink (input valid, group_target_id, centroid_x, centroid_y,
                  centroid_z, fixation_us, output ready);
endinterface

/* sv/gaze_fixation_detector.sv */
// ============================================================================
// gaze_fixation_detector
// Velocity-threshold fixation grouping of gaze samples with centroid output.
// ============================================================================
// One sample at a time. A fixation sample may also have the group centroid
// and split test evaluated. All of it runs through one bit-serial unit that
// retires one multiplier bit or one quotient bit per cycle. A finished group
// waits in the output register while the next sample is processed; the block
// stalls only if a second group is ready before the first has been taken.
module gaze_fixation_detector #(
    parameter int MAX_GROUP_POINTS = 65535
) (
    input  logic                          clk,
    input  logic                          rst_n,
    gfd_sample_if.sink                    sample_in,
    gfd_group_if.source                   group_out,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [gfd_pkg::PADDR_W-1:0]   paddr,
    input  logic [gfd_pkg::PDATA_W-1:0]   pwdata,
    output logic [gfd_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready
);
    import gfd_pkg::*;

    localparam int CNT_W = $clog2(MAX_GROUP_POINTS + 1);

    // configuration
    logic [LIM_W-1:0]   fix_lim_reg, sac_lim_reg, split_reg, min_time_reg;
    logic               emit_en_reg;
    logic               cfg_wr;
    logic [2:0]         cfg_idx;

    // sequencer
    gfd_state_t         state_reg, state_next;
    logic               started_reg, started_next;
    logic               mode_fix_reg, mode_fix_next;
    logic               step_done;

    // current sample
    logic signed [POS_W-1:0] px_reg, py_reg, pz_reg;
    logic signed [POS_W-1:0] px_next, py_next, pz_next;
    logic [ID_W-1:0]    id_reg, id_next;
    logic [DT_W-1:0]    dt_reg, dt_next;

    // detector state
    logic signed [POS_W-1:0] lx_reg, ly_reg, lz_reg;
    logic signed [POS_W-1:0] lx_next, ly_next, lz_next;
    logic               open_reg, open_next;
    logic [ID_W-1:0]    gid_reg, gid_next;
    logic signed [SUM_W-1:0] sx_reg, sy_reg, sz_reg;
    logic signed [SUM_W-1:0] sx_next, sy_next, sz_next;
    logic [CNT_W-1:0]   point_count_reg, point_count_next;
    logic [TIME_W-1:0]  time_reg, time_next;

    // intermediate results
    logic [SPEED_W-1:0] speed_reg, speed_next;
    logic [SPL2_W-1:0]  split2_reg, split2_next;
    logic signed [MEAN_W-1:0] mx_reg, my_reg, mz_reg;
    logic signed [MEAN_W-1:0] mx_next, my_next, mz_next;

    // output register
    logic               out_valid_reg, out_valid_next;
    logic [ID_W-1:0]    out_id_reg, out_id_next;
    logic [POS_W-1:0]   out_cx_reg, out_cy_reg, out_cz_reg;
    logic [POS_W-1:0]   out_cx_next, out_cy_next, out_cz_next;
    logic [TIME_W-1:0]  out_time_reg, out_time_next;

    // shared unit
    alu_cmd_t           alu_cmd;
    logic [A_W-1:0]     alu_a;
    logic [B_W-1:0]     alu_b;
    logic               alu_busy;
    logic [ACC_W-1:0]   alu_acc;
    logic [DIVD_W-1:0]  alu_quo;
    logic [DVS_W-1:0]   alu_rem;

    // datapath helpers
    logic signed [SUB_W-1:0]  sub_l, sub_r, sub_d;
    logic [SUB_W-1:0]         sub_mag;
    logic signed [SUM_W-1:0]  sum_sel;
    logic [SUM_W:0]           sum_mag;
    logic [MEAN_W-1:0]        q_adj;
    logic signed [MEAN_W-1:0] mean_val;
    logic                     emit_cond;
    logic                     out_blocked;
    logic [TIME_W:0]          time_sum;
    logic signed [SUM_W:0]    ax_sum, ay_sum, az_sum;

    gfd_alu u_alu (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (alu_cmd),
        .a     (alu_a),
        .b     (alu_b),
        .busy  (alu_busy),
        .acc   (alu_acc),
        .quo   (alu_quo),
        .rem   (alu_rem)
    );

    // ------------------------------------------------------------------
    // configuration port
    // ------------------------------------------------------------------
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[4:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fix_lim_reg  <= '0;
            sac_lim_reg  <= '0;
            split_reg    <= '0;
            min_time_reg <= '0;
            emit_en_reg  <= 1'b0;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                REG_FIX_LIMIT: fix_lim_reg  <= pwdata[LIM_W-1:0];
                REG_SAC_LIMIT: sac_lim_reg  <= pwdata[LIM_W-1:0];
                REG_SPLIT:     split_reg    <= pwdata[LIM_W-1:0];
                REG_MIN_TIME:  min_time_reg <= pwdata[LIM_W-1:0];
                REG_EMIT:      emit_en_reg  <= pwdata[0];
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            REG_FIX_LIMIT: prdata = PDATA_W'(fix_lim_reg);
            REG_SAC_LIMIT: prdata = PDATA_W'(sac_lim_reg);
            REG_SPLIT:     prdata = PDATA_W'(split_reg);
            REG_MIN_TIME:  prdata = PDATA_W'(min_time_reg);
            REG_EMIT:      prdata = PDATA_W'(emit_en_reg);
            default:       prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            started_reg     <= 1'b0;
            mode_fix_reg    <= 1'b0;
            lx_reg          <= -24'sd256;
            ly_reg          <= -24'sd256;
            lz_reg          <= -24'sd256;
            open_reg        <= 1'b0;
            gid_reg         <= NO_TARGET;
            sx_reg          <= '0;
            sy_reg          <= '0;
            sz_reg          <= '0;
            point_count_reg <= '0;
            time_reg        <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            started_reg     <= started_next;
            mode_fix_reg    <= mode_fix_next;
            lx_reg          <= lx_next;
            ly_reg          <= ly_next;
            lz_reg          <= lz_next;
            open_reg        <= open_next;
            gid_reg         <= gid_next;
            sx_reg          <= sx_next;
            sy_reg          <= sy_next;
            sz_reg          <= sz_next;
            point_count_reg <= point_count_next;
            time_reg        <= time_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        px_reg       <= px_next;
        py_reg       <= py_next;
        pz_reg       <= pz_next;
        id_reg       <= id_next;
        dt_reg       <= dt_next;
        speed_reg    <= speed_next;
        split2_reg   <= split2_next;
        mx_reg       <= mx_next;
        my_reg       <= my_next;
        mz_reg       <= mz_next;
        out_id_reg   <= out_id_next;
        out_cx_reg   <= out_cx_next;
        out_cy_reg   <= out_cy_next;
        out_cz_reg   <= out_cz_next;
        out_time_reg <= out_time_next;
    end

    // ------------------------------------------------------------------
    // operand selection
    // ------------------------------------------------------------------
    always_comb
    begin
        sub_l   = '0;
        sub_r   = '0;
        sum_sel = '0;
        unique case (state_reg)
            ST_D2X:  begin sub_l = SUB_W'(px_reg); sub_r = SUB_W'(lx_reg); end
            ST_D2Y:  begin sub_l = SUB_W'(py_reg); sub_r = SUB_W'(ly_reg); end
            ST_D2Z:  begin sub_l = SUB_W'(pz_reg); sub_r = SUB_W'(lz_reg); end
            ST_C2X:  begin sub_l = SUB_W'(px_reg); sub_r = SUB_W'(mx_reg); end
            ST_C2Y:  begin sub_l = SUB_W'(py_reg); sub_r = SUB_W'(my_reg); end
            ST_C2Z:  begin sub_l = SUB_W'(pz_reg); sub_r = SUB_W'(mz_reg); end
            ST_DIVX: sum_sel = sx_reg;
            ST_DIVY: sum_sel = sy_reg;
            ST_DIVZ: sum_sel = sz_reg;
            default: ;
        endcase
        sub_d   = sub_l - sub_r;
        sub_mag = sub_d[SUB_W-1] ? SUB_W'(-sub_d) : SUB_W'(sub_d);
        sum_mag = sum_sel[SUM_W-1] ? (SUM_W+1)'(-(SUM_W+1)'(sum_sel))
                                   : (SUM_W+1)'(sum_sel);
        // floor toward minus infinity
        q_adj   = MEAN_W'(alu_quo)
                + MEAN_W'(sum_sel[SUM_W-1] && (alu_rem != '0));
        if (point_count_reg == '0)
        begin
            mean_val = '0;
        end
        else
        begin
            mean_val = sum_sel[SUM_W-1] ? -$signed(q_adj) : $signed(q_adj);
        end
    end

    always_comb
    begin
        alu_cmd.start = (state_reg != ST_IDLE) && (state_reg != ST_CLOSE)
                     && (state_reg != ST_ADD) && !started_reg;
        alu_cmd.op    = ALU_MUL;
        alu_cmd.clear = 1'b1;
        alu_cmd.nbits = NB_DIFF;
        alu_a         = '0;
        alu_b         = '0;
        unique case (state_reg)
            ST_D2X, ST_D2Y, ST_D2Z:
            begin
                alu_cmd.clear = (state_reg == ST_D2X);
                alu_a = A_W'(sub_mag);
                alu_b = B_W'(sub_mag);
            end
            ST_SPD:
            begin
                alu_cmd.nbits = NB_US2;
                alu_a = alu_acc[A_W-1:0];
                alu_b = US2_CONST;
            end
            ST_FDT, ST_SDT:
            begin
                alu_cmd.nbits = NB_DT;
                alu_a = (state_reg == ST_FDT) ? A_W'(fix_lim_reg) : A_W'(sac_lim_reg);
                alu_b = B_W'(dt_reg);
            end
            ST_FSQ, ST_SSQ:
            begin
                alu_cmd.nbits = NB_LIMDT;
                alu_a = A_W'(alu_acc[43:0]);
                alu_b = B_W'(alu_acc[43:0]);
            end
            ST_SPLSQ:
            begin
                alu_cmd.nbits = NB_SPLIT;
                alu_a = A_W'(split_reg);
                alu_b = B_W'(split_reg);
            end
            ST_DIVX, ST_DIVY, ST_DIVZ:
            begin
                alu_cmd.op    = ALU_DIV;
                alu_cmd.nbits = NB_DIV;
                alu_a = A_W'(sum_mag);
                alu_b = B_W'(DVS_W'(point_count_reg));
            end
            ST_C2X, ST_C2Y, ST_C2Z:
            begin
                alu_cmd.clear = (state_reg == ST_C2X);
                alu_cmd.nbits = NB_C2;
                alu_a = A_W'(sub_mag);
                alu_b = B_W'(sub_mag);
            end
            default: ;
        endcase
    end

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    assign step_done   = started_reg && !alu_busy;
    assign emit_cond   = open_reg && emit_en_reg && (time_reg >= TIME_W'(min_time_reg));
    assign out_blocked = out_valid_reg && !group_out.ready;
    assign time_sum    = (TIME_W+1)'(time_reg) + (TIME_W+1)'(dt_reg);
    assign ax_sum      = (SUM_W+1)'(sx_reg) + (SUM_W+1)'(px_reg);
    assign ay_sum      = (SUM_W+1)'(sy_reg) + (SUM_W+1)'(py_reg);
    assign az_sum      = (SUM_W+1)'(sz_reg) + (SUM_W+1)'(pz_reg);
    assign sample_in.ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next       = state_reg;
        started_next     = started_reg;
        mode_fix_next    = mode_fix_reg;
        px_next          = px_reg;
        py_next          = py_reg;
        pz_next          = pz_reg;
        id_next          = id_reg;
        dt_next          = dt_reg;
        lx_next          = lx_reg;
        ly_next          = ly_reg;
        lz_next          = lz_reg;
        open_next        = open_reg;
        gid_next         = gid_reg;
        sx_next          = sx_reg;
        sy_next          = sy_reg;
        sz_next          = sz_reg;
        point_count_next = point_count_reg;
        time_next        = time_reg;
        speed_next       = speed_reg;
        split2_next      = split2_reg;
        mx_next          = mx_reg;
        my_next          = my_reg;
        mz_next          = mz_reg;
        out_valid_next   = out_blocked;
        out_id_next      = out_id_reg;
        out_cx_next      = out_cx_reg;
        out_cy_next      = out_cy_reg;
        out_cz_next      = out_cz_reg;
        out_time_next    = out_time_reg;

        if (alu_cmd.start)
        begin
            started_next = 1'b1;
        end
        else if (step_done)
        begin
            started_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (sample_in.valid)
                begin
                    px_next = sample_in.pos_x;
                    py_next = sample_in.pos_y;
                    pz_next = sample_in.pos_z;
                    id_next = sample_in.target_id;
                    dt_next = (sample_in.elapsed_us == '0) ? DT_W'(1)
                                                           : sample_in.elapsed_us;
                    if (sample_in.sample_valid)
                    begin
                        state_next = ST_D2X;
                    end
                end
            end
            ST_D2X:
            begin
                if (step_done) state_next = ST_D2Y;
            end
            ST_D2Y:
            begin
                if (step_done) state_next = ST_D2Z;
            end
            ST_D2Z:
            begin
                if (step_done)
                begin
                    lx_next = px_reg;
                    ly_next = py_reg;
                    lz_next = pz_reg;
                    state_next = (id_reg == NO_TARGET) ? ST_IDLE : ST_SPD;
                end
            end
            ST_SPD:
            begin
                if (step_done)
                begin
                    speed_next = alu_acc[SPEED_W-1:0];
                    state_next = ST_FDT;
                end
            end
            ST_FDT:
            begin
                if (step_done) state_next = ST_FSQ;
            end
            ST_FSQ:
            begin
                if (step_done)
                begin
                    if (speed_reg < SPEED_W'(alu_acc[LSQ_W-1:0]))
                    begin
                        mode_fix_next = 1'b1;
                        if (!open_reg)
                        begin
                            open_next        = 1'b1;
                            gid_next         = id_reg;
                            sx_next          = '0;
                            sy_next          = '0;
                            sz_next          = '0;
                            point_count_next = '0;
                            time_next        = '0;
                            state_next       = ST_ADD;
                        end
                        else if (point_count_reg == '0)
                        begin
                            state_next = ST_ADD;
                        end
                        else
                        begin
                            state_next = ST_SPLSQ;
                        end
                    end
                    else
                    begin
                        state_next = ST_SDT;
                    end
                end
            end
            ST_SDT:
            begin
                if (step_done) state_next = ST_SSQ;
            end
            ST_SSQ:
            begin
                if (step_done)
                begin
                    if ((speed_reg > SPEED_W'(alu_acc[LSQ_W-1:0])) && open_reg)
                    begin
                        mode_fix_next = 1'b0;
                        state_next    = ST_DIVX;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_SPLSQ:
            begin
                if (step_done)
                begin
                    split2_next = alu_acc[SPL2_W-1:0];
                    state_next  = ST_DIVX;
                end
            end
            ST_DIVX:
            begin
                if (step_done)
                begin
                    mx_next    = mean_val;
                    state_next = ST_DIVY;
                end
            end
            ST_DIVY:
            begin
                if (step_done)
                begin
                    my_next    = mean_val;
                    state_next = ST_DIVZ;
                end
            end
            ST_DIVZ:
            begin
                if (step_done)
                begin
                    mz_next    = mean_val;
                    state_next = mode_fix_reg ? ST_C2X : ST_CLOSE;
                end
            end
            ST_C2X:
            begin
                if (step_done) state_next = ST_C2Y;
            end
            ST_C2Y:
            begin
                if (step_done) state_next = ST_C2Z;
            end
            ST_C2Z:
            begin
                if (step_done)
                begin
                    state_next = (alu_acc[C2_W-1:0] > C2_W'(split2_reg)) ? ST_CLOSE
                                                                        : ST_ADD;
                end
            end
            ST_CLOSE:
            begin
                if (!out_blocked)
                begin
                    if (emit_cond)
                    begin
                        out_valid_next = 1'b1;
                        out_id_next    = gid_reg;
                        out_cx_next    = mx_reg[POS_W-1:0];
                        out_cy_next    = my_reg[POS_W-1:0];
                        out_cz_next    = mz_reg[POS_W-1:0];
                        out_time_next  = time_reg;
                    end
                    open_next = 1'b0;
                    if (mode_fix_reg)
                    begin
                        open_next        = 1'b1;
                        gid_next         = id_reg;
                        sx_next          = '0;
                        sy_next          = '0;
                        sz_next          = '0;
                        point_count_next = '0;
                        time_next        = '0;
                        state_next       = ST_ADD;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_ADD:
            begin
                if (point_count_reg < CNT_W'(MAX_GROUP_POINTS))
                begin
                    sx_next = (ax_sum[SUM_W] != ax_sum[SUM_W-1])
                            ? {ax_sum[SUM_W], {(SUM_W-1){~ax_sum[SUM_W]}}}
                            : ax_sum[SUM_W-1:0];
                    sy_next = (ay_sum[SUM_W] != ay_sum[SUM_W-1])
                            ? {ay_sum[SUM_W], {(SUM_W-1){~ay_sum[SUM_W]}}}
                            : ay_sum[SUM_W-1:0];
                    sz_next = (az_sum[SUM_W] != az_sum[SUM_W-1])
                            ? {az_sum[SUM_W], {(SUM_W-1){~az_sum[SUM_W]}}}
                            : az_sum[SUM_W-1:0];
                    point_count_next = point_count_reg + 1'b1;
                end
                time_next  = time_sum[TIME_W] ? '1 : time_sum[TIME_W-1:0];
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign group_out.valid           = out_valid_reg;
    assign group_out.group_target_id = out_id_reg;
    assign group_out.centroid_x      = out_cx_reg;
    assign group_out.centroid_y      = out_cy_reg;
    assign group_out.centroid_z      = out_cz_reg;
    assign group_out.fixation_us     = out_time_reg;

`ifndef SYNTHESIS
    a_start_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        alu_cmd.start |-> !alu_busy)
        else $error("shared unit started while busy");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        point_count_reg <= CNT_W'(MAX_GROUP_POINTS))
        else $error("point count above limit");

    a_add_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ADD) |=> (point_count_reg != '0))
        else $error("group empty after adding a point");
`endif

endmodule

/* sv/gfd_alu.sv */
// ============================================================================
// gfd_alu
// Bit-serial shift-add multiply-accumulate and restoring divide unit.
// ============================================================================
module gfd_alu (
    input  logic                      clk,
    input  logic                      rst_n,
    input  gfd_pkg::alu_cmd_t         cmd,
    input  logic [gfd_pkg::A_W-1:0]   a,
    input  logic [gfd_pkg::B_W-1:0]   b,
    output logic                      busy,
    output logic [gfd_pkg::ACC_W-1:0] acc,
    output logic [gfd_pkg::DIVD_W-1:0] quo,
    output logic [gfd_pkg::DVS_W-1:0] rem
);
    import gfd_pkg::*;

    alu_op_t            op_reg, op_next;
    logic [NB_W-1:0]    cnt_reg, cnt_next;
    logic [ACC_W-1:0]   acc_reg, acc_next;
    logic [ACC_W-1:0]   mcand_reg, mcand_next;
    logic [B_W-1:0]     mplier_reg, mplier_next;
    logic [DIVD_W-1:0]  quo_reg, quo_next;
    logic [DVS_W-1:0]   rem_reg, rem_next;
    logic [DVS_W-1:0]   dvs_reg, dvs_next;
    logic [DVS_W:0]     trial;
    logic [DVS_W:0]     trial_diff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_reg  <= ALU_MUL;
            cnt_reg <= '0;
        end
        else
        begin
            op_reg  <= op_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg    <= acc_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        quo_reg    <= quo_next;
        rem_reg    <= rem_next;
        dvs_reg    <= dvs_next;
    end

    always_comb
    begin
        op_next     = op_reg;
        cnt_next    = cnt_reg;
        acc_next    = acc_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        quo_next    = quo_reg;
        rem_next    = rem_reg;
        dvs_next    = dvs_reg;
        trial       = {rem_reg, quo_reg[DIVD_W-1]};
        trial_diff  = trial - {1'b0, dvs_reg};

        if (cmd.start)
        begin
            op_next     = cmd.op;
            cnt_next    = cmd.nbits;
            mcand_next  = ACC_W'(a);
            mplier_next = b;
            quo_next    = a[DIVD_W-1:0];
            rem_next    = '0;
            dvs_next    = b[DVS_W-1:0];
            if (cmd.clear)
            begin
                acc_next = '0;
            end
        end
        else if (cnt_reg != '0)
        begin
            cnt_next = cnt_reg - 1'b1;
            unique case (op_reg)
                ALU_MUL:
                begin
                    if (mplier_reg[0])
                    begin
                        acc_next = acc_reg + mcand_reg;
                    end
                    mcand_next  = {mcand_reg[ACC_W-2:0], 1'b0};
                    mplier_next = {1'b0, mplier_reg[B_W-1:1]};
                end
                ALU_DIV:
                begin
                    if (!trial_diff[DVS_W])
                    begin
                        rem_next = trial_diff[DVS_W-1:0];
                        quo_next = {quo_reg[DIVD_W-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_next = trial[DVS_W-1:0];
                        quo_next = {quo_reg[DIVD_W-2:0], 1'b0};
                    end
                end
                default:
                begin
                    cnt_next = '0;
                end
            endcase
        end
    end

    assign busy = (cnt_reg != '0);
    assign acc  = acc_reg;
    assign quo  = quo_reg;
    assign rem  = rem_reg;

endmodule

/* verif/tb.sv */
`timescale 1ns / 100ps
// ============================================================================
// tb
// Self-checking bench for the gaze fixation detector. Directed samples and
// random fixation/saccade sequences go in on the sample channel; every group
// that comes out is checked field by field against an in-bench I-VT grouping
// model (or the group listed with a directed sample), under several register settings written over the APB port.
// ============================================================================
module tb;
    import gfd_pkg::*;

    localparam logic [2:0] REG_UNUSED = 3'd5;
    localparam int SETTLE_CYCLES = 600;
    localparam int PHASE_ITEMS = 90;
    localparam int QUIET_ITEMS = 60;
    localparam int MAX_POINTS = 65535;
    localparam longint US_PER_S = 1000000;

    typedef struct packed {
        logic                   sv;
        logic signed [15:0]     id;
        logic signed [23:0]     x;
        logic signed [23:0]     y;
        logic signed [23:0]     z;
        logic [19:0]            dt;
    } sample_t;

    typedef struct packed {
        logic signed [15:0]     id;
        logic signed [23:0]     cx;
        logic signed [23:0]     cy;
        logic signed [23:0]     cz;
        logic [31:0]            us;
    } group_t;

    typedef struct packed {
        sample_t                s;
        logic                   typed;
        group_t                 g;
    } row_t;

    typedef struct packed {
        logic [23:0]            fix;
        logic [23:0]            sac;
        logic [23:0]            split;
        logic [23:0]            min_us;
        logic                   emit;
    } setting_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [PDATA_W-1:0] pwdata = '0;
    logic [PDATA_W-1:0] prdata;
    logic pready;

    gfd_sample_if sample_bus ();
    gfd_group_if group_bus ();

    gaze_fixation_detector dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample_in (sample_bus),
        .group_out (group_bus),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always #1 clk = ~clk;

    initial
    begin
        #5000000;
        $display("CHECKS FAILED");
        $finish;
    end

    // grouping model state
    logic [23:0] fix_limit, sac_limit, split_dist, min_time;
    logic emit_on;
    longint last_pt [3];
    logic grp_open;
    logic [15:0] grp_id;
    longint grp_sum [3];
    int unsigned grp_cnt;
    logic [31:0] grp_us;

    group_t expected_groups [$];
    int mismatches = 0;
    bit quiet = 1'b0;
    int stall_left = 0;
    longint ctr [3];
    logic [15:0] cur_id;

    function automatic longint floor_mean(longint s, longint c);
        if (c == 0)
            return 0;
        if (s >= 0)
            return s / c;
        return -((-s + c - 1) / c);
    endfunction

    function automatic logic [127:0] square_of(longint d);
        logic [127:0] m;
        m = (d < 0) ? -d : d;
        return m * m;
    endfunction

    function automatic longint sat_sum(longint s, longint v);
        longint r;
        r = s + v;
        if (r > 64'sd549755813887)
            return 64'sd549755813887;
        if (r < -64'sd549755813888)
            return -64'sd549755813888;
        return r;
    endfunction

    function automatic bit close_group(output group_t g);
        bit hit;
        hit = grp_open && emit_on && (grp_us >= 32'(min_time));
        g.id = grp_id;
        g.cx = 24'(floor_mean(grp_sum[0], grp_cnt));
        g.cy = 24'(floor_mean(grp_sum[1], grp_cnt));
        g.cz = 24'(floor_mean(grp_sum[2], grp_cnt));
        g.us = grp_us;
        grp_open = 1'b0;
        return hit;
    endfunction

    function automatic void open_group(logic [15:0] id);
        grp_open = 1'b1;
        grp_id = id;
        grp_sum[0] = 0;
        grp_sum[1] = 0;
        grp_sum[2] = 0;
        grp_cnt = 0;
        grp_us = '0;
    endfunction

    function automatic bit predict_group(input sample_t s, output group_t g);
        longint p [3];
        longint dt;
        logic [127:0] d2, speed, lim, c2;
        bit hit;
        hit = 1'b0;
        g = '0;
        if (!s.sv)
            return 1'b0;
        p[0] = s.x;
        p[1] = s.y;
        p[2] = s.z;
        dt = (s.dt == 0) ? 1 : longint'(s.dt);
        d2 = square_of(p[0] - last_pt[0]) + square_of(p[1] - last_pt[1])
           + square_of(p[2] - last_pt[2]);
        last_pt = p;
        if (s.id == NO_TARGET)
            return 1'b0;
        speed = d2 * 128'(US_PER_S * US_PER_S);
        lim = square_of(longint'(fix_limit) * dt);
        if (speed < lim)
        begin
            if (!grp_open)
                open_group(s.id);
            if (grp_cnt > 0)
            begin
                c2 = square_of(p[0] - floor_mean(grp_sum[0], grp_cnt))
                   + square_of(p[1] - floor_mean(grp_sum[1], grp_cnt))
                   + square_of(p[2] - floor_mean(grp_sum[2], grp_cnt));
                if (c2 > square_of(longint'(split_dist)))
                begin
                    hit = close_group(g);
                    open_group(s.id);
                end
            end
            if (grp_cnt < MAX_POINTS)
            begin
                for (int i = 0; i < 3; i++)
                    grp_sum[i] = sat_sum(grp_sum[i], p[i]);
                grp_cnt++;
            end
            if (longint'(grp_us) + dt > 64'hFFFF_FFFF)
                grp_us = '1;
            else
                grp_us = 32'(longint'(grp_us) + dt);
            return hit;
        end
        lim = square_of(longint'(sac_limit) * dt);
        if (speed > lim && grp_open)
            hit = close_group(g);
        return hit;
    endfunction

    task automatic apb_write(logic [2:0] idx, logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_FIX_LIMIT: fix_limit = value[23:0];
            REG_SAC_LIMIT: sac_limit = value[23:0];
            REG_SPLIT:     split_dist = value[23:0];
            REG_MIN_TIME:  min_time = value[23:0];
            REG_EMIT:      emit_on = value[0];
            default: ;
        endcase
    endtask

    task automatic apply_setting(setting_t c);
        apb_write(REG_FIX_LIMIT, 32'(c.fix));
        apb_write(REG_SAC_LIMIT, 32'(c.sac));
        apb_write(REG_SPLIT, 32'(c.split));
        apb_write(REG_MIN_TIME, 32'(c.min_us));
        apb_write(REG_EMIT, 32'(c.emit));
    endtask

    task automatic drain_groups();
        while (expected_groups.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // hold valid across back-to-back transfers; drop it only for a gap
    task automatic send_sample(sample_t s, bit typed, group_t typed_g);
        group_t g;
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            sample_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        sample_bus.valid <= 1'b1;
        sample_bus.sample_valid <= s.sv;
        sample_bus.target_id <= s.id;
        sample_bus.pos_x <= s.x;
        sample_bus.pos_y <= s.y;
        sample_bus.pos_z <= s.z;
        sample_bus.elapsed_us <= s.dt;
        do
            @(posedge clk);
        while (!sample_bus.ready);
        if (predict_group(s, g))
            expected_groups.push_back(typed ? typed_g : g);
    endtask

    function automatic longint jitter(longint a);
        if (a <= 0)
            return 0;
        return longint'($urandom_range(0, 32'(2 * a))) - a;
    endfunction

    function automatic logic signed [23:0] clamp24(longint v);
        if (v > 8388607)
            return 24'sh7FFFFF;
        if (v < -8388608)
            return 24'sh800000;
        return 24'(v);
    endfunction

    function automatic sample_t make_sample();
        sample_t s;
        int r;
        longint allow;
        r = $urandom_range(0, 99);
        s.sv = 1'b1;
        s.id = cur_id;
        s.dt = ($urandom_range(0, 3) == 0) ? 20'($urandom_range(100000, 1048575))
                                           : 20'($urandom_range(200, 20000));
        allow = longint'(fix_limit) * s.dt / US_PER_S;
        if (allow > 1000000)
            allow = 1000000;
        if (r < 8)
        begin
            s = sample_t'({$urandom, $urandom, $urandom, $urandom});
            if ($urandom_range(0, 3) == 0)
                s.sv = 1'b0;
            return s;
        end
        if (r < 20)
        begin
            for (int i = 0; i < 3; i++)
                ctr[i] = longint'($signed(24'($urandom)));
            cur_id = ($urandom_range(0, 1) != 0) ? 16'($urandom_range(0, 15))
                                                  : 16'($urandom);
            s.id = cur_id;
            s.dt = 20'($urandom_range(1, 50));
        end
        else if (r < 28)
        begin
            for (int i = 0; i < 3; i++)
                ctr[i] = ctr[i] + jitter(allow / 4);
        end
        if (r >= 20 && r < 24)
            s.id = NO_TARGET;
        s.x = clamp24(ctr[0] + jitter(allow / 5));
        s.y = clamp24(ctr[1] + jitter(allow / 5));
        s.z = clamp24(ctr[2] + jitter(allow / 5));
        return s;
    endfunction

    always @(posedge clk)
    begin
        if (quiet)
            group_bus.ready <= 1'b1;
        else if (stall_left > 0)
        begin
            group_bus.ready <= 1'b0;
            stall_left--;
        end
        else if ($urandom_range(0, 7) == 0)
        begin
            group_bus.ready <= 1'b0;
            stall_left = $urandom_range(0, 6);
        end
        else
            group_bus.ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        group_t got, want;
        if (rst_n && group_bus.valid && group_bus.ready)
        begin
            got.id = group_bus.group_target_id;
            got.cx = group_bus.centroid_x;
            got.cy = group_bus.centroid_y;
            got.cz = group_bus.centroid_z;
            got.us = group_bus.fixation_us;
            if (expected_groups.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected group transfer: id %0d c (%0d %0d %0d) us %0d",
                             got.id, got.cx, got.cy, got.cz, got.us);
            end
            else
            begin
                want = expected_groups.pop_front();
                if (got.id !== want.id || got.cx !== want.cx || got.cy !== want.cy
                    || got.cz !== want.cz || got.us !== want.us)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("group mismatch: exp id %0d c (%0d %0d %0d) us %0d, got id %0d c (%0d %0d %0d) us %0d",
                                 want.id, want.cx, want.cy, want.cz, want.us,
                                 got.id, got.cx, got.cy, got.cz, got.us);
                end
            end
        end
    end

    row_t directed [12] = '{
        '{'{1'b0, 16'sd9, 24'sd1, 24'sd2, 24'sd3, 20'd10}, 1'b0, '0},
        '{'{1'b1, -16'sd1, 24'sd0, 24'sd0, 24'sd0, 20'd1000}, 1'b0, '0},
        '{'{1'b1, 16'sd5, 24'sd0, 24'sd0, 24'sd0, 20'd1000}, 1'b0, '0},
        '{'{1'b1, 16'sd5, 24'sd10, 24'sd0, 24'sd0, 20'd0}, 1'b1,
          '{16'sd5, 24'sd0, 24'sd0, 24'sd0, 32'd1000}},
        '{'{1'b1, -16'sd42, 24'sd10, 24'sd0, 24'sd0, 20'd1000}, 1'b0, '0},
        '{'{1'b1, -16'sd42, 24'sd12, 24'sd0, 24'sd0, 20'd1000}, 1'b0, '0},
        '{'{1'b1, 16'sd7, 24'sd5000, 24'sd0, 24'sd0, 20'd1000000}, 1'b1,
          '{-16'sd42, 24'sd11, 24'sd0, 24'sd0, 32'd2000}},
        '{'{1'b1, 16'sh7FFF, 24'sh7FFFFF, 24'sh800000, 24'sh7FFFFF, 20'hFFFFF}, 1'b1,
          '{16'sd7, 24'sd5000, 24'sd0, 24'sd0, 32'd1000000}},
        '{'{1'b1, 16'sh8000, 24'sh800000, 24'sh7FFFFF, 24'sh800000, 20'd1}, 1'b0, '0},
        '{'{1'b1, 16'sd3, 24'sh800000, 24'sh7FFFFF, 24'sh800000, 20'hFFFFF}, 1'b0, '0},
        '{'{1'b1, 16'sd3, 24'sh800000, 24'sh7FFFFF, 24'sh800000, 20'd0}, 1'b0, '0},
        '{'{1'b1, 16'sd3, 24'sd0, 24'sd0, 24'sd0, 20'd1}, 1'b1,
          '{16'sd3, 24'sh800000, 24'sh7FFFFF, 24'sh800000, 32'd1048576}}
    };

    setting_t phases [5] = '{
        '{24'd1000000, 24'd3000000, 24'd2000, 24'd0, 1'b1},
        '{24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 1'b1},
        '{24'd500000, 24'd500000, 24'd300, 24'd5000, 1'b0},
        '{24'd0, 24'd0, 24'd0, 24'd0, 1'b1},
        '{24'd2000000, 24'd8000000, 24'd5000, 24'd3000, 1'b1}
    };

    initial
    begin
        sample_bus.valid = 1'b0;
        sample_bus.sample_valid = 1'b0;
        sample_bus.target_id = '0;
        sample_bus.pos_x = '0;
        sample_bus.pos_y = '0;
        sample_bus.pos_z = '0;
        sample_bus.elapsed_us = '0;
        group_bus.ready = 1'b0;
        fix_limit = '0;
        sac_limit = '0;
        split_dist = '0;
        min_time = '0;
        emit_on = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            last_pt[i] = -256;
            grp_sum[i] = 0;
            ctr[i] = 0;
        end
        grp_open = 1'b0;
        grp_id = NO_TARGET;
        grp_cnt = 0;
        grp_us = '0;
        cur_id = 16'd1;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        apply_setting('{24'd1000000, 24'd5000000, 24'd1000, 24'd0, 1'b1});
        apb_write(REG_UNUSED, 32'hFFFF_FFFF);
        foreach (directed[i])
            send_sample(directed[i].s, directed[i].typed, directed[i].g);
        sample_bus.valid <= 1'b0;

        foreach (phases[p])
        begin
            drain_groups();
            apply_setting(phases[p]);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (p == 0 && n == PHASE_ITEMS / 2)
                begin
                    sample_bus.valid <= 1'b0;
                    drain_groups();
                end
                if (p == $size(phases) - 1 && n == PHASE_ITEMS - QUIET_ITEMS)
                    quiet = 1'b1;
                send_sample(make_sample(), 1'b0, '0);
            end
            sample_bus.valid <= 1'b0;
        end

        drain_groups();
        if (mismatches == 0 && expected_groups.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
